>>> rtl/sexpr_token_lexer_defines.svh
// Assertion helpers shared by the lexer checker.
`ifndef SEXPR_TOKEN_LEXER_DEFINES_SVH
`define SEXPR_TOKEN_LEXER_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define SXL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sexpr lexer check failed");

// Next-cycle implication, also checked across reset.
`define SXL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sexpr lexer check failed");

`endif

>>> rtl/sxl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sxl_pkg;

  // Character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_ESCAPE = 8'h5C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [30:0] INT_LIMIT = 31'h7FFF_FFFF;
  localparam logic [31:0] POS_MAX   = 32'hFFFF_FFFF;

  // Result queue sizing
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  typedef enum logic [2:0] {
    EV_STR_CHAR   = 3'd0,
    EV_SYM_CHAR   = 3'd1,
    EV_STR_END    = 3'd2,
    EV_SYM_END    = 3'd3,
    EV_LPAREN     = 3'd4,
    EV_RPAREN     = 3'd5,
    EV_MISS_QUOTE = 3'd6,
    EV_BAD_NUMBER = 3'd7
  } ev_t;

  // One result beat
  typedef struct packed {
    ev_t          ev;
    logic [7:0]   chr;
    logic [31:0]  line;
    logic [31:0]  col;
    logic         is_number;
    logic         is_float;
    logic [30:0]  int_value;
    logic         last;
  } res_t;

  // Results caused by one input beat
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } lex_out_t;

endpackage

`default_nettype wire

>>> rtl/sexpr_token_lexer.sv
`timescale 1ns / 1ps
`default_nettype none

// S-expression byte lexer.
// Input channel (in_valid/in_ready): one beat per source byte, kind = 0, or
// an end-of-input marker, kind = 1. Output channel (out_valid/out_ready):
// one beat per event (string/symbol char, string/symbol end, parens,
// missing quote, bad number), each tagged with the token's start line and
// column; last marks the final event caused by an input beat.
// Each accepted byte updates the lexer state in the cycle it is accepted and
// drops its zero, one or two events into a four-entry result queue; the first
// event is visible on the output the cycle after acceptance if the queue was empty.
// Throughput: one byte per cycle while in_ready stays high and each byte causes
// at most one event; a byte causing two events (a symbol closed by a paren) is
// drained through the single read port of the result queue, one event per read.
// in_ready drops when fewer than two queue slots are free, so a stalled
// receiver backs up the input without losing data.
// Reset clears the queue, the line/column counters and the lexer state.
module sexpr_token_lexer import sxl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       event_res,
  output logic [7:0]       out_byte,
  output logic [31:0]      start_line,
  output logic [31:0]      start_column,
  output logic             is_number,
  output logic             is_float,
  output logic [30:0]      int_value,
  output logic             last
);

  lex_out_t lo;
  res_t     dout;
  logic     fire;

  assign fire = in_valid && in_ready;

  sxl_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .kind    (kind),
    .in_byte (in_byte),
    .lo      (lo)
  );

  sxl_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (fire),
    .lo        (lo),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (dout)
  );

  // Output fields
  assign event_res    = dout.ev;
  assign out_byte     = dout.chr;
  assign start_line   = dout.line;
  assign start_column = dout.col;
  assign is_number    = dout.is_number;
  assign is_float     = dout.is_float;
  assign int_value    = dout.int_value;
  assign last         = dout.last;

endmodule

`default_nettype wire

>>> rtl/sxl_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sxl_core import sxl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic       kind,
  input  wire logic [7:0] in_byte,
  output lex_out_t        lo
);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_STR  = 3'b010,
    MODE_SYM  = 3'b100
  } mode_t;

  typedef enum logic [2:0] {
    CLS_OTHER, CLS_LPAREN, CLS_RPAREN, CLS_QUOTE, CLS_ESCAPE, CLS_SPACE
  } cls_t;

  typedef struct packed {
    logic        numeric;
    logic [1:0]  pc;
    logic        dseen;
    logic        dbsp;
    logic [30:0] acc;
    logic        ovf;
  } num_t;

  localparam num_t NUM_CLEAR = '{numeric: 1'b1, pc: 2'd0, dseen: 1'b0, dbsp: 1'b0,
                                 acc: '0, ovf: 1'b0};

  function automatic cls_t classify(logic [7:0] c);
    cls_t r;
    if (c == CH_LPAREN) r = CLS_LPAREN;
    else if (c == CH_RPAREN) r = CLS_RPAREN;
    else if (c == CH_QUOTE) r = CLS_QUOTE;
    else if (c == CH_ESCAPE) r = CLS_ESCAPE;
    else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) r = CLS_SPACE;
    else r = CLS_OTHER;
    return r;
  endfunction

  // Number tracking for one symbol character; acc*10 as two shifts
  function automatic num_t num_feed(num_t s, logic [7:0] c);
    num_t        r;
    logic [34:0] v;
    r = s;
    v = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {31'd0, c[3:0]};
    if (c == CH_POINT) begin
      if (s.pc == 2'd1) r.dbsp = s.dseen;
      if (s.pc != 2'd2) r.pc = s.pc + 2'd1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      r.dseen = 1'b1;
      if (s.pc == 2'd0 && !s.ovf) begin
        if (v > {4'd0, INT_LIMIT}) begin
          r.ovf = 1'b1;
          r.acc = INT_LIMIT;
        end else begin
          r.acc = v[30:0];
        end
      end
    end else begin
      r.numeric = 1'b0;
    end
    return r;
  endfunction

  function automatic res_t mk(ev_t ev, logic [7:0] c, logic [31:0] ln, logic [31:0] cl);
    res_t r;
    r = '0;
    r.ev   = ev;
    r.chr  = c;
    r.line = ln;
    r.col  = cl;
    return r;
  endfunction

  // Symbol end or bad number, from the number tracker
  function automatic res_t end_sym(num_t s, logic [31:0] ln, logic [31:0] cl);
    res_t r;
    r = mk(EV_SYM_END, 8'h00, ln, cl);
    if (!s.numeric) begin
      r.ev = EV_SYM_END;
    end else if (s.pc == 2'd0) begin
      if (s.ovf) begin
        r.ev = EV_BAD_NUMBER;
      end else begin
        r.is_number = 1'b1;
        r.int_value = s.acc;
      end
    end else if (s.pc == 2'd1) begin
      if (s.dseen) begin
        r.is_number = 1'b1;
        r.is_float  = 1'b1;
      end else begin
        r.ev = EV_BAD_NUMBER;
      end
    end else if (!s.dbsp) begin
      r.ev = EV_BAD_NUMBER;
    end
    return r;
  endfunction

  mode_t       mode, mode_next;
  logic        esc, esc_next;
  logic        started, started_next;
  logic [31:0] line_cnt, line_next;
  logic [31:0] col_cnt, col_next;
  logic [31:0] tok_line, tok_line_next;
  logic [31:0] tok_col, tok_col_next;
  num_t        num, num_next;

  cls_t        cls, cls_eff;
  logic        open_new;
  logic        push;
  res_t        new_res;

  assign cls = classify(in_byte);

  // Per-beat lexer update
  always_comb begin
    mode_next     = mode;
    esc_next      = esc;
    started_next  = started;
    line_next     = line_cnt;
    col_next      = col_cnt;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    num_next      = num;
    lo            = '0;
    cls_eff       = cls;
    open_new      = 1'b0;
    push          = 1'b0;
    new_res       = '0;

    if (kind) begin
      // End of input: flush symbol or flag an open string
      unique case (mode)
        MODE_SYM: begin
          lo.r0 = end_sym(num, tok_line, tok_col);
          lo.n  = 2'd1;
        end
        MODE_STR: begin
          lo.r0 = mk(EV_MISS_QUOTE, 8'h00, tok_line, tok_col);
          lo.n  = 2'd1;
        end
        default: ;
      endcase
      mode_next    = MODE_IDLE;
      esc_next     = 1'b0;
      started_next = 1'b0;
    end else begin
      // Position counters
      col_next = (col_cnt == POS_MAX) ? col_cnt : col_cnt + 32'd1;
      if (in_byte == CH_NL) begin
        line_next = (line_cnt == POS_MAX) ? line_cnt : line_cnt + 32'd1;
        col_next  = '0;
      end

      if (started || !(in_byte == CH_SPACE || in_byte == CH_NL)) begin
        if (!started) begin
          started_next  = 1'b1;
          tok_line_next = line_next;
          tok_col_next  = col_next;
        end
        if (esc) begin
          cls_eff  = CLS_OTHER;
          esc_next = 1'b0;
        end
        if (!esc && cls == CLS_ESCAPE) begin
          esc_next = 1'b1;
        end else begin
          unique case (mode)
            MODE_STR: begin
              if (cls_eff == CLS_QUOTE) begin
                lo.r0        = mk(EV_STR_END, 8'h00, tok_line_next, tok_col_next);
                mode_next    = MODE_IDLE;
                started_next = 1'b0;
              end else begin
                lo.r0 = mk(EV_STR_CHAR, in_byte, tok_line_next, tok_col_next);
              end
              lo.n = 2'd1;
            end
            MODE_SYM: begin
              if (cls_eff == CLS_OTHER) begin
                lo.r0    = mk(EV_SYM_CHAR, in_byte, tok_line_next, tok_col_next);
                num_next = num_feed(num, in_byte);
              end else begin
                lo.r0     = end_sym(num, tok_line_next, tok_col_next);
                mode_next = MODE_IDLE;
                if (cls_eff == CLS_SPACE) begin
                  started_next = 1'b0;
                end else begin
                  // The delimiter opens its own token at the same position
                  tok_line_next = line_next;
                  tok_col_next  = col_next;
                  open_new      = 1'b1;
                end
              end
              lo.n = 2'd1;
            end
            default: open_new = 1'b1;
          endcase

          if (open_new) begin
            mode_next = MODE_IDLE;
            unique case (cls_eff)
              CLS_QUOTE: mode_next = MODE_STR;
              CLS_OTHER: begin
                mode_next = MODE_SYM;
                num_next  = num_feed(NUM_CLEAR, in_byte);
                new_res   = mk(EV_SYM_CHAR, in_byte, tok_line_next, tok_col_next);
                push      = 1'b1;
              end
              CLS_LPAREN: begin
                new_res      = mk(EV_LPAREN, 8'h00, tok_line_next, tok_col_next);
                push         = 1'b1;
                started_next = 1'b0;
              end
              CLS_RPAREN: begin
                new_res      = mk(EV_RPAREN, 8'h00, tok_line_next, tok_col_next);
                push         = 1'b1;
                started_next = 1'b0;
              end
              default: ;
            endcase
            if (push) begin
              if (lo.n == 2'd0) lo.r0 = new_res;
              else lo.r1 = new_res;
              lo.n = lo.n + 2'd1;
            end
          end
        end
      end
    end

    // Mark the final result of this beat
    if (lo.n == 2'd1) lo.r0.last = 1'b1;
    if (lo.n == 2'd2) lo.r1.last = 1'b1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      esc      <= 1'b0;
      started  <= 1'b0;
      line_cnt <= '0;
      col_cnt  <= '0;
      tok_line <= '0;
      tok_col  <= '0;
      num      <= NUM_CLEAR;
    end else if (fire) begin
      mode     <= mode_next;
      esc      <= esc_next;
      started  <= started_next;
      line_cnt <= line_next;
      col_cnt  <= col_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
      num      <= num_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sxl_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module sxl_out_fifo import sxl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr_en,
  input  wire lex_out_t lo,
  output logic          room,
  output logic          out_valid,
  input  wire logic     out_ready,
  output res_t          dout
);

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic [FIFO_AW:0]   n_push;
  logic               pop;

  // Room for the two results one beat can cause
  assign room      = (count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign out_valid = (count != '0);
  assign dout      = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign n_push    = wr_en ? {{(FIFO_AW-1){1'b0}}, lo.n} : '0;

  // Result storage
  always_ff @(posedge clk) begin
    if (wr_en && lo.n != 2'd0) mem[wr_ptr] <= lo.r0;
    if (wr_en && lo.n == 2'd2) mem[wr_ptr + FIFO_AW'(1)] <= lo.r1;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[FIFO_AW-1:0];
      if (pop) rd_ptr <= rd_ptr + FIFO_AW'(1);
      count <= count + n_push - {{FIFO_AW{1'b0}}, pop};
    end
  end

endmodule

`default_nettype wire

>>> rtl/sxl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sexpr_token_lexer_defines.svh"

module sxl_checker import sxl_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  event_res,
  input wire logic [7:0]  out_byte,
  input wire logic [31:0] start_line,
  input wire logic [31:0] start_column,
  input wire logic        is_number,
  input wire logic        is_float,
  input wire logic [30:0] int_value,
  input wire logic        last
);

  // Queue empties on reset
  `SXL_ASSERT_NXT(a_reset_empty, rst, !out_valid && in_ready)

  // A stalled result beat holds
  `SXL_ASSERT_NXT(a_out_hold, !rst && out_valid && !out_ready,
    rst || (out_valid && $stable(event_res) && $stable(out_byte) && $stable(start_line) && $stable(start_column) && $stable(last)))

  // Only character events carry a byte
  `SXL_ASSERT_IMP(a_byte_zero,
    out_valid && event_res != EV_STR_CHAR && event_res != EV_SYM_CHAR, out_byte == 8'h00)

  // Number flags only on a symbol end
  `SXL_ASSERT_IMP(a_num_sym_end, out_valid && is_number, event_res == EV_SYM_END)

  // A float is a number with no integer value
  `SXL_ASSERT_IMP(a_float_num, out_valid && is_float, is_number && int_value == '0)

endmodule

bind sexpr_token_lexer sxl_checker u_sxl_checker (.*);

`default_nettype wire

>>> bench/sexpr_token_lexer_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the lexer, predicts the event stream for every
// accepted input beat, and compares each output beat against the oldest
// predicted event.
module sexpr_token_lexer_checker import sxl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  event_res,
  input  logic [7:0]  out_byte,
  input  logic [31:0] start_line,
  input  logic [31:0] start_column,
  input  logic        is_number,
  input  logic        is_float,
  input  logic [30:0] int_value,
  input  logic        last,
  output int          mismatches,
  output int          events_due
);

  typedef enum logic [1:0] {LEX_IDLE, LEX_STRING, LEX_SYMBOL} lex_mode_t;
  typedef enum logic [2:0] {
    CL_OTHER, CL_LPAREN, CL_RPAREN, CL_QUOTE, CL_ESCAPE, CL_SPACE
  } char_class_t;

  // Lexer state mirror
  lex_mode_t   mode;
  logic        esc_pending;
  logic        token_open;
  logic [31:0] line_cnt;
  logic [31:0] col_cnt;
  logic [31:0] tok_line;
  logic [31:0] tok_col;

  // Number scan state for the current symbol
  logic        all_numeric;
  logic [1:0]  points;
  logic        digit_seen;
  logic        digit_before_2nd;
  logic [31:0] num_acc;
  logic        num_ovf;

  res_t awaited_events[$];
  int   errors = 0;

  function automatic char_class_t classify(logic [7:0] c);
    if (c == CH_LPAREN) return CL_LPAREN;
    if (c == CH_RPAREN) return CL_RPAREN;
    if (c == CH_QUOTE) return CL_QUOTE;
    if (c == CH_ESCAPE) return CL_ESCAPE;
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return CL_SPACE;
    return CL_OTHER;
  endfunction

  function automatic res_t make_event(ev_t ev, logic [7:0] ch, logic num, logic flt,
                                      logic [30:0] val);
    res_t r;
    r.ev        = ev;
    r.chr       = ch;
    r.line      = tok_line;
    r.col       = tok_col;
    r.is_number = num;
    r.is_float  = flt;
    r.int_value = val;
    r.last      = 1'b0;
    return r;
  endfunction

  // Symbol end or bad number, from the number scan state
  function automatic res_t symbol_end_event();
    if (!all_numeric) return make_event(EV_SYM_END, 8'h00, 1'b0, 1'b0, '0);
    if (points == 2'd0) begin
      if (num_ovf) return make_event(EV_BAD_NUMBER, 8'h00, 1'b0, 1'b0, '0);
      return make_event(EV_SYM_END, 8'h00, 1'b1, 1'b0, num_acc[30:0]);
    end
    if (points == 2'd1) begin
      if (digit_seen) return make_event(EV_SYM_END, 8'h00, 1'b1, 1'b1, '0);
      return make_event(EV_BAD_NUMBER, 8'h00, 1'b0, 1'b0, '0);
    end
    if (digit_before_2nd) return make_event(EV_SYM_END, 8'h00, 1'b0, 1'b0, '0);
    return make_event(EV_BAD_NUMBER, 8'h00, 1'b0, 1'b0, '0);
  endfunction

  task automatic number_clear();
    all_numeric      = 1'b1;
    points           = 2'd0;
    digit_seen       = 1'b0;
    digit_before_2nd = 1'b0;
    num_acc          = '0;
    num_ovf          = 1'b0;
  endtask

  task automatic number_feed(logic [7:0] c);
    logic [63:0] v;
    if (c == CH_POINT) begin
      if (points == 2'd1) digit_before_2nd = digit_seen;
      if (points < 2'd2) points++;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      digit_seen = 1'b1;
      if (points == 2'd0 && !num_ovf) begin
        v = {32'd0, num_acc} * 64'd10 + 64'(c - CH_ZERO);
        if (v > 64'(INT_LIMIT)) begin
          num_ovf = 1'b1;
          num_acc = {1'b0, INT_LIMIT};
        end else begin
          num_acc = v[31:0];
        end
      end
    end else begin
      all_numeric = 1'b0;
    end
  endtask

  task automatic mark_token_start();
    token_open = 1'b1;
    tok_line   = line_cnt;
    tok_col    = col_cnt;
  endtask

  // Predict the events of one input beat and queue them
  task automatic lex_step(logic eoi, logic [7:0] c);
    res_t        ev_buf [2];
    int          n;
    char_class_t cls;
    logic        start_new;
    n = 0;
    if (eoi) begin
      if (mode == LEX_SYMBOL) begin
        ev_buf[n] = symbol_end_event();
        n++;
      end else if (mode == LEX_STRING) begin
        ev_buf[n] = make_event(EV_MISS_QUOTE, 8'h00, 1'b0, 1'b0, '0);
        n++;
      end
      mode        = LEX_IDLE;
      esc_pending = 1'b0;
      token_open  = 1'b0;
    end else begin
      if (col_cnt != POS_MAX) col_cnt++;
      if (c == CH_NL) begin
        if (line_cnt != POS_MAX) line_cnt++;
        col_cnt = '0;
      end
      // spaces and newlines between tokens are skipped without latching a position
      if (!token_open) begin
        if (c == CH_SPACE || c == CH_NL) return;
        mark_token_start();
      end
      cls = classify(c);
      if (esc_pending) begin
        cls         = CL_OTHER;
        esc_pending = 1'b0;
      end else if (cls == CL_ESCAPE) begin
        esc_pending = 1'b1;
        return;
      end

      if (mode == LEX_STRING) begin
        if (cls == CL_QUOTE) begin
          ev_buf[n] = make_event(EV_STR_END, 8'h00, 1'b0, 1'b0, '0);
          n++;
          mode       = LEX_IDLE;
          token_open = 1'b0;
        end else begin
          ev_buf[n] = make_event(EV_STR_CHAR, c, 1'b0, 1'b0, '0);
          n++;
        end
      end else begin
        start_new = 1'b1;
        if (mode == LEX_SYMBOL) begin
          if (cls == CL_OTHER) begin
            ev_buf[n] = make_event(EV_SYM_CHAR, c, 1'b0, 1'b0, '0);
            n++;
            number_feed(c);
            start_new = 1'b0;
          end else begin
            // symbol closes first; a paren or quote then opens its own token
            ev_buf[n] = symbol_end_event();
            n++;
            mode = LEX_IDLE;
            if (cls == CL_SPACE) begin
              token_open = 1'b0;
              start_new  = 1'b0;
            end else begin
              mark_token_start();
            end
          end
        end
        if (start_new) begin
          mode = LEX_IDLE;
          case (cls)
            CL_QUOTE: mode = LEX_STRING;
            CL_OTHER: begin
              mode = LEX_SYMBOL;
              number_clear();
              number_feed(c);
              ev_buf[n] = make_event(EV_SYM_CHAR, c, 1'b0, 1'b0, '0);
              n++;
            end
            CL_LPAREN: begin
              ev_buf[n] = make_event(EV_LPAREN, 8'h00, 1'b0, 1'b0, '0);
              n++;
              token_open = 1'b0;
            end
            CL_RPAREN: begin
              ev_buf[n] = make_event(EV_RPAREN, 8'h00, 1'b0, 1'b0, '0);
              n++;
              token_open = 1'b0;
            end
            default: ;
          endcase
        end
      end
    end
    if (n > 0) ev_buf[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) awaited_events.push_back(ev_buf[i]);
  endtask

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    logic bad;
    if (rst) begin
      mode        = LEX_IDLE;
      esc_pending = 1'b0;
      token_open  = 1'b0;
      line_cnt    = '0;
      col_cnt     = '0;
      tok_line    = '0;
      tok_col     = '0;
      number_clear();
      awaited_events.delete();
    end else begin
      // predict first, so a same-edge result still finds its expectation
      if (in_valid && in_ready) lex_step(kind, in_byte);

      if (out_valid && out_ready) begin
        got.ev        = ev_t'(event_res);
        got.chr       = out_byte;
        got.line      = start_line;
        got.col       = start_column;
        got.is_number = is_number;
        got.is_float  = is_float;
        got.int_value = int_value;
        got.last      = last;
        if (awaited_events.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: output beat with nothing awaited: ev=%0d chr=%02h line=%0d col=%0d",
                     $realtime, got.ev, got.chr, got.line, got.col);
        end else begin
          want = awaited_events.pop_front();
          bad = (got.ev !== want.ev) || (got.chr !== want.chr) ||
                (got.line !== want.line) || (got.col !== want.col) ||
                (got.is_number !== want.is_number) || (got.is_float !== want.is_float) ||
                (got.int_value !== want.int_value) || (got.last !== want.last);
          if (bad) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: event mismatch", $realtime);
              $display("  expected ev=%0d chr=%02h line=%0d col=%0d num=%b flt=%b val=%0d last=%b",
                       want.ev, want.chr, want.line, want.col, want.is_number,
                       want.is_float, want.int_value, want.last);
              $display("  actual   ev=%0d chr=%02h line=%0d col=%0d num=%b flt=%b val=%0d last=%b",
                       got.ev, got.chr, got.line, got.col, got.is_number,
                       got.is_float, got.int_value, got.last);
            end
          end
        end
      end
    end
    mismatches <= errors;
    events_due <= awaited_events.size();
  end

endmodule

>>> bench/sexpr_token_lexer_test.sv
`timescale 1ns / 1ps

module sexpr_token_lexer_test;
  import sxl_pkg::*;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOI  = 1'b1;
  localparam int   TOTAL_BEATS = 1040;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = KIND_BYTE;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_res;
  logic [7:0]  out_byte;
  logic [31:0] start_line;
  logic [31:0] start_column;
  logic        is_number;
  logic        is_float;
  logic [30:0] int_value;
  logic        last;
  int          mismatches;
  int          events_due;
  int          beats_sent = 0;
  logic        calm;

  // no idling on either side through the middle of the run
  assign calm = (beats_sent >= 450) && (beats_sent < 650);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sexpr_token_lexer uut (.*);

  sexpr_token_lexer_checker check_lex (.*);

  // Hard stop
  initial begin
    #4_800_000;
    $display("sexpr_token_lexer_test failed");
    $finish;
  end

  // Offer one beat and hold it until accepted
  task automatic send_beat(input logic k, input logic [7:0] b);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(KIND_BYTE, s[i]);
  endtask

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // One random token, blank, end-of-input marker or stray byte, plus an optional separator
  task automatic send_random_token();
    int         pick;
    int         len;
    logic [7:0] ch;
    pick = $urandom_range(99);
    if (pick < 28) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1) == 0) send_text("2147483647");
        else send_text("2147483648");
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
        repeat (len) send_beat(KIND_BYTE, random_digit());
      end
    end else if (pick < 40) begin
      // digits and points: floats, bad numbers, dotted symbols
      len = $urandom_range(1, 6);
      repeat (len) begin
        ch = ($urandom_range(2) == 0) ? CH_POINT : random_digit();
        send_beat(KIND_BYTE, ch);
      end
    end else if (pick < 55) begin
      len = $urandom_range(1, 6);
      repeat (len) send_beat(KIND_BYTE, 8'($urandom_range(33, 126)));
    end else if (pick < 70) begin
      send_beat(KIND_BYTE, CH_QUOTE);
      len = $urandom_range(0, 6);
      repeat (len) begin
        if ($urandom_range(4) == 0) begin
          send_beat(KIND_BYTE, CH_ESCAPE);
          send_beat(KIND_BYTE, 8'($urandom_range(255)));
        end else begin
          ch = 8'($urandom_range(255));
          if (ch == CH_QUOTE || ch == CH_ESCAPE) ch = CH_POINT;
          send_beat(KIND_BYTE, ch);
        end
      end
      if ($urandom_range(9) != 0) send_beat(KIND_BYTE, CH_QUOTE);
    end else if (pick < 80) begin
      send_beat(KIND_BYTE, ($urandom_range(1) == 0) ? CH_LPAREN : CH_RPAREN);
    end else if (pick < 88) begin
      case ($urandom_range(5))
        0: send_beat(KIND_BYTE, CH_SPACE);
        1: send_beat(KIND_BYTE, CH_NL);
        2: send_beat(KIND_BYTE, CH_TAB);
        3: send_beat(KIND_BYTE, CH_CR);
        default: send_beat(KIND_BYTE, 8'($urandom_range(11, 12)));
      endcase
    end else if (pick < 93) begin
      send_beat(KIND_EOI, 8'($urandom_range(255)));
    end else begin
      send_beat(KIND_BYTE, 8'($urandom_range(255)));
    end
    case ($urandom_range(5))
      0, 1, 2: send_beat(KIND_BYTE, CH_SPACE);
      3: send_beat(KIND_BYTE, CH_NL);
      4: send_beat(KIND_BYTE, CH_RPAREN);
      default: ;
    endcase
  endtask

  // Receiver: random stalls, two long hold-offs that back up the input
  initial begin : receiver
    int stall_left;
    int holds_done;
    stall_left = 0;
    holds_done = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ((holds_done == 0 && beats_sent >= 250) ||
                   (holds_done == 1 && beats_sent >= 820)) begin
        out_ready <= 1'b0;
        stall_left = 399;
        holds_done++;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 18);
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // tab latches a start, paren keeps it; float closed by a paren
    send_beat(KIND_BYTE, CH_TAB);
    send_text("(1.5)");
    // string with an escaped quote and a zero byte
    send_text("\"\\\"");
    send_beat(KIND_BYTE, 8'h00);
    // lone point closed by a quote, then an open string at end of input
    send_text("\".\"");
    send_beat(KIND_EOI, 8'hFF);
    send_beat(KIND_BYTE, CH_NL);
    // dotted plain symbol, integer closed by a paren
    send_text("7.. 42(");
    // top byte, escape dropped by end of input
    send_beat(KIND_BYTE, 8'hFF);
    send_text("\\");
    send_beat(KIND_EOI, 8'h00);
    // two points with no digit
    send_text("..");
    send_beat(KIND_EOI, 8'h00);

    while (beats_sent < TOTAL_BEATS) send_random_token();
    in_valid <= 1'b0;

    // drain: a byte causes two events at most
    @(posedge clk);
    while (events_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && events_due == 0 && !out_valid) begin
      $display("sexpr_token_lexer_test passed");
    end else begin
      $display("sexpr_token_lexer_test failed");
    end
    $finish;
  end

endmodule
